@@ hw/rtl/thcp_pkg.sv @@
// ----------------------------------------------------------------------------
// thcp_pkg: shared constants and helpers for the tagged hex coordinate parser
// byte codes, register indexes, target codes, hex digit decode, mod-5 bump
// ----------------------------------------------------------------------------
`default_nettype none

package thcp_pkg;

  localparam int unsigned MSG_CAPACITY = 32;
  localparam int unsigned KEPT_BYTES   = 12;
  localparam int unsigned POS_W        = $clog2(MSG_CAPACITY + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TAG_W   = 24;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned TGT_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 * COORD_W - COUNT_W;

  localparam logic [BYTE_W-1:0] CHAR_START = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_END   = 8'h0A;

  localparam logic [TAG_W-1:0] CAR_TAG_RST        = 24'h435654;
  localparam logic [TAG_W-1:0] BALL_TAG_RST       = 24'h425244;
  localparam logic [TAG_W-1:0] SECOND_CAR_TAG_RST = 24'h435654;

  localparam logic [CFG_IDX_W-1:0] CFG_CAR_TAG        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_TAG       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CAR_TAG = 2'd2;

  localparam logic [TGT_W-1:0] TARGET_CAR        = 2'd0;
  localparam logic [TGT_W-1:0] TARGET_BALL       = 2'd1;
  localparam logic [TGT_W-1:0] TARGET_SECOND_CAR = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  // lowercase hex only, anything else reads as zero
  function automatic logic [3:0] hex_digit(input byte_t c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 4'(c[3:0] + 4'd9);
    end
    return d;
  endfunction

  function automatic logic [COUNT_W-1:0] bump_mod5(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] n;
    case (c)
      3'd0:    n = 3'd1;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd0;
      3'd5:    n = 3'd1;
      3'd6:    n = 3'd2;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tagged_hex_coordinate_parser.sv @@
// ----------------------------------------------------------------------------
// tagged_hex_coordinate_parser
// parses ':'-framed tagged messages into object coordinates and update counts
// ----------------------------------------------------------------------------
// One received byte is taken per cycle, sustained while m_tready does not stall
// the output: an accepted byte lands in an input register, and
// the message buffer update, tag compare, hex decode and counter bump all
// happen in one pass into the output register. A '\n' byte produces a result
// word only when the first three buffered bytes match a tag (car first, then
// ball, then second car); m_tuser carries the target code and m_tdata the
// coordinates and the new modulo-5 count. Tags are written through the cfg
// port while the stream is idle; the user must ensure this, the block does not.
`default_nettype none

module tagged_hex_coordinate_parser (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [thcp_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [thcp_pkg::OUT_DATA_W-1:0]        m_tdata,   // [11:0] coord_x,
                                                            // [23:12] coord_y,
                                                            // [26:24] update_count
  output logic [thcp_pkg::TGT_W-1:0]             m_tuser,   // [1:0] target
  input  wire logic                              cfg_we,
  input  wire logic [thcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [thcp_pkg::TAG_W-1:0]        cfg_data
);
  import thcp_pkg::*;

  logic [TAG_W-1:0]   car_tag, ball_tag, second_car_tag;

  logic               in_valid;
  byte_t              in_byte;

  logic               in_message;
  logic [POS_W-1:0]   write_pos;
  byte_t              msg_bytes [KEPT_BYTES];
  logic [COUNT_W-1:0] car_counter, ball_counter;

  logic               advance;
  logic [TAG_W-1:0]   head;
  logic               hit_car, hit_ball, hit_second;
  logic [COORD_W-1:0] x_dec, y_dec;
  logic [COUNT_W-1:0] new_count;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign head = {msg_bytes[0], msg_bytes[1], msg_bytes[2]};
  assign hit_car    = (head == car_tag);
  assign hit_ball   = (head == ball_tag);
  assign hit_second = (head == second_car_tag);

  assign x_dec = {hex_digit(msg_bytes[6]), hex_digit(msg_bytes[7]),
                  hex_digit(msg_bytes[8])};
  assign y_dec = {hex_digit(msg_bytes[9]), hex_digit(msg_bytes[10]),
                  hex_digit(msg_bytes[11])};

  // ball only counts on its own when the car tag did not match first
  assign new_count = (hit_ball && !hit_car) ? bump_mod5(ball_counter)
                                            : bump_mod5(car_counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      car_tag        <= CAR_TAG_RST;
      ball_tag       <= BALL_TAG_RST;
      second_car_tag <= SECOND_CAR_TAG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAR_TAG:        car_tag        <= cfg_data;
        CFG_BALL_TAG:       ball_tag       <= cfg_data;
        CFG_SECOND_CAR_TAG: second_car_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // message state, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message   <= 1'b0;
      write_pos    <= '0;
      car_counter  <= '0;
      ball_counter <= '0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < KEPT_BYTES; i++) begin
        msg_bytes[i] <= '0;
      end
    end else begin
      if (advance && in_byte == CHAR_END) begin
        m_tvalid <= hit_car || hit_ball || hit_second;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        if (in_byte == CHAR_START) begin
          in_message <= 1'b1;
          write_pos  <= '0;
        end else if (in_byte != CHAR_END) begin
          if (in_message && write_pos < POS_W'(MSG_CAPACITY)) begin
            for (int i = 0; i < KEPT_BYTES; i++) begin
              if (write_pos == POS_W'(i)) begin
                msg_bytes[i] <= in_byte;
              end
            end
            write_pos <= write_pos + 1'b1;
          end
        end else begin
          in_message <= 1'b0;
          m_tdata    <= {{OUT_PAD_W{1'b0}}, new_count, y_dec, x_dec};
          // car wins over ball, ball over second car
          if (hit_car) begin
            car_counter <= bump_mod5(car_counter);
            m_tuser     <= TARGET_CAR;
          end else if (hit_ball) begin
            ball_counter <= bump_mod5(ball_counter);
            m_tuser      <= TARGET_BALL;
          end else if (hit_second) begin
            car_counter <= bump_mod5(car_counter);
            m_tuser     <= TARGET_SECOND_CAR;
          end
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    write_pos <= POS_W'(MSG_CAPACITY))
    else $error("write position past capacity");

  a_counters_mod5: assert property (@(posedge clk) disable iff (rst)
    car_counter < 3'd5 && ball_counter < 3'd5)
    else $error("update counter left modulo-5 range");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte == CHAR_START |=> in_message && write_pos == '0)
    else $error("start byte did not open a message");

  a_ball_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == TARGET_BALL |-> m_tdata[2*COORD_W +: COUNT_W] == ball_counter)
    else $error("ball result count differs from ball counter");

  a_car_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == TARGET_CAR || m_tuser == TARGET_SECOND_CAR)
    |-> m_tdata[2*COORD_W +: COUNT_W] == car_counter)
    else $error("car result count differs from car counter");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid)
    else $error("input stalled with nothing pending");

endmodule

`default_nettype wire
